FILE: rtl/csvs_pkg.sv
// csvs_pkg: types, character codes and the per-byte parse step of the CSV splitter.
// Depends on nothing; every other file but csvs_ifs refers to it by scoped names.
package csvs_pkg;

    // Result run sizing: one input byte yields at most MAX_OUT results
    localparam int MAX_OUT   = 8;
    localparam int RUN_IDX_W = $clog2(MAX_OUT);
    localparam int RUN_CNT_W = $clog2(MAX_OUT + 1);

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    typedef enum logic [2:0] {
        ST_START    = 3'd0,
        ST_UNQUOTED = 3'd1,
        ST_QUOTED   = 3'd2,
        ST_ESCAPE   = 3'd3
    } t_parse_st;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_FEND = 2'd1,
        KIND_REND = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        t_res [MAX_OUT-1:0]   res;
        logic [RUN_CNT_W-1:0] cnt;
    } t_run;

    typedef struct packed {
        t_parse_st  st;
        logic       fhb;   // field has bytes
        logic       rhf;   // row has fields
        logic       hcr;   // CR held for one byte
        logic [1:0] bom;   // BOM bytes matched
        logic       ats;   // at text start
    } t_ctx;

    typedef struct packed {
        t_ctx ctx;
        t_run run;
    } t_work;

    // Front to queue: one run per accepted item that produces results
    typedef struct packed {
        logic en;
        t_run run;
    } t_push;

    // Queue to back: head run and whether it is there
    typedef struct packed {
        logic valid;
        t_run run;
    } t_head;

    localparam t_ctx CTX_RESET = '{ST_START, 1'b0, 1'b0, 1'b0, 2'd0, 1'b1};

    // Append one result, dropping anything past the run capacity
    function automatic t_work f_emit(t_work w, t_kind k, logic [7:0] d);
        t_work r;
        r = w;
        if (r.run.cnt < RUN_CNT_W'(MAX_OUT)) begin
            r.run.res[r.run.cnt[RUN_IDX_W-1:0]].kind = k;
            r.run.res[r.run.cnt[RUN_IDX_W-1:0]].data = (k == KIND_BYTE) ? d : 8'h00;
            r.run.cnt = r.run.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic t_work f_close(t_work w);
        t_work r;
        r = f_emit(w, KIND_FEND, 8'h00);
        r.ctx.rhf = 1'b1;
        r.ctx.fhb = 1'b0;
        r.ctx.st  = ST_START;
        return r;
    endfunction

    function automatic t_work f_end_row(t_work w);
        t_work r;
        r = f_emit(w, KIND_REND, 8'h00);
        r.ctx.rhf = 1'b0;
        return r;
    endfunction

    function automatic t_work f_content(t_work w, logic [7:0] c);
        t_work r;
        r = f_emit(w, KIND_BYTE, c);
        r.ctx.fhb = 1'b1;
        return r;
    endfunction

    // One byte through the quote/field machine
    function automatic t_work f_process(t_work w, logic [7:0] c);
        t_work r;
        r = w;
        case (w.ctx.st)
            ST_UNQUOTED: begin
                if (c == CH_COMMA) begin
                    r = f_close(r);
                end else if (c == CH_LF) begin
                    r = f_end_row(f_close(r));
                end else begin
                    r = f_content(r, c);
                end
            end
            ST_QUOTED: begin
                if (c == CH_QUOTE) begin
                    r.ctx.st = ST_ESCAPE;
                end else begin
                    r = f_content(r, c);
                end
            end
            ST_ESCAPE: begin
                if (c == CH_QUOTE) begin
                    r = f_content(r, CH_QUOTE);
                    r.ctx.st = ST_QUOTED;
                end else if (c == CH_COMMA) begin
                    r = f_close(r);
                end else if (c == CH_LF) begin
                    r = f_end_row(f_close(r));
                end else begin
                    // stray byte after a closing quote is dropped
                    r.ctx.st = ST_QUOTED;
                end
            end
            default: begin
                if (c == CH_COMMA) begin
                    r = f_close(r);
                end else if (c == CH_LF) begin
                    r = f_end_row(f_close(r));
                end else if (c == CH_QUOTE) begin
                    r.ctx.fhb = 1'b0;
                    r.ctx.st  = ST_QUOTED;
                end else begin
                    r.ctx.st = ST_UNQUOTED;
                    r = f_content(r, c);
                end
            end
        endcase
        return r;
    endfunction

    // CR stage: hold a CR until the next byte shows whether LF follows
    function automatic t_work f_feed(t_work w, logic [7:0] c, logic last);
        t_work r;
        r = w;
        if (r.ctx.hcr) begin
            r.ctx.hcr = 1'b0;
            if (c != CH_LF) begin
                r = f_process(r, CH_CR);
            end
        end
        if (c == CH_CR && !last) begin
            r.ctx.hcr = 1'b1;
        end else begin
            r = f_process(r, c);
        end
        return r;
    endfunction

    // Full per-byte step: BOM skip, CR stage, parse, end-of-data flush
    function automatic t_work f_step(t_ctx ctx, logic [7:0] c, logic last);
        t_work      r;
        logic       consumed;
        logic [1:0] p;
        r        = '0;
        r.ctx    = ctx;
        consumed = 1'b0;
        p        = ctx.bom;
        if (ctx.ats) begin
            if (p == 2'd0 && c == BOM_B0 && !last) begin
                r.ctx.bom = 2'd1;
                consumed  = 1'b1;
            end else if (p == 2'd1 && c == BOM_B1 && !last) begin
                r.ctx.bom = 2'd2;
                consumed  = 1'b1;
            end else if (p == 2'd2 && c == BOM_B2) begin
                r.ctx.bom = 2'd0;
                r.ctx.ats = 1'b0;
                consumed  = 1'b1;
            end else begin
                // broken BOM: replay the matched bytes as text
                if (p >= 2'd1) begin
                    r = f_feed(r, BOM_B0, 1'b0);
                end
                if (p >= 2'd2) begin
                    r = f_feed(r, BOM_B1, 1'b0);
                end
                r.ctx.bom = 2'd0;
                r.ctx.ats = 1'b0;
            end
        end
        if (!consumed) begin
            r = f_feed(r, c, last);
        end
        if (last) begin
            if (r.ctx.hcr) begin
                r.ctx.hcr = 1'b0;
                r = f_process(r, CH_CR);
            end
            if (r.ctx.fhb) begin
                r = f_close(r);
            end
            if (r.ctx.rhf) begin
                r = f_end_row(r);
            end
            r.ctx = CTX_RESET;
        end
        return r;
    endfunction

endpackage

FILE: rtl/csvs_ifs.sv
// Channel interfaces of the CSV splitter: text bytes in, parse results out.
// Depends on nothing; payload widths follow the block's field list.
interface csvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source(output valid, output data_byte, output end_of_data, input ready);
    modport sink(input valid, input data_byte, input end_of_data, output ready);
endinterface

interface csvs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] content_byte;
    logic       last_of_run;

    modport source(output valid, output item_kind, output content_byte,
                   output last_of_run, input ready);
    modport sink(input valid, input item_kind, input content_byte,
                 input last_of_run, output ready);
endinterface

FILE: rtl/csvs_front.sv
// csvs_front: accepts text bytes, runs the parse step and pushes result runs.
// Depends on csvs_pkg and csvs_in_if.
module csvs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csvs_in_if.sink            i_in,
    input  logic               i_full,
    output csvs_pkg::t_push    o_push
);

    csvs_pkg::t_ctx  r_ctx;
    csvs_pkg::t_ctx  n_ctx;
    csvs_pkg::t_work w_step;
    logic            w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;

    // Evaluate the step for the byte on the channel
    always_comb begin
        w_step = csvs_pkg::f_step(r_ctx, i_in.data_byte, i_in.end_of_data);
    end

    // Next state: advance only on an accepted item
    always_comb begin
        n_ctx = r_ctx;
        if (w_accept) begin
            n_ctx = w_step.ctx;
        end
    end

    // Outputs: push a run only when the item produced results
    always_comb begin
        o_push.en  = w_accept && (w_step.run.cnt != '0);
        o_push.run = w_step.run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= csvs_pkg::CTX_RESET;
        end else begin
            r_ctx <= n_ctx;
        end
    end

endmodule

FILE: rtl/csvs_run_fifo.sv
// csvs_run_fifo: short queue of result runs between front and back.
// Depends on csvs_pkg for the run and handshake structs.
module csvs_run_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csvs_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output csvs_pkg::t_head o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csvs_pkg::t_run   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.run   = r_mem[r_rd_ptr];

    // Store the pushed run
    always_ff @(posedge i_clk) begin
        if (i_push.en) begin
            r_mem[r_wr_ptr] <= i_push.run;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push.en, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.en |-> (r_count != CNT_W'(DEPTH)))
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("run popped from an empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.en && !i_pop) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("queue occupancy lost a push");

endmodule

FILE: rtl/csvs_back.sv
// csvs_back: head run to output register, one result per cycle while ready.
// Depends on csvs_pkg and csvs_out_if.
module csvs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csvs_pkg::t_head i_head,
    output logic            o_pop,
    csvs_out_if.source      o_out
);

    localparam int IDX_W = csvs_pkg::RUN_IDX_W;
    localparam int CNT_W = csvs_pkg::RUN_CNT_W;

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    csvs_pkg::t_res   r_out;
    logic             r_out_last;
    csvs_pkg::t_res   w_sel;
    logic             w_sel_last;
    logic             w_load;

    assign w_sel      = i_head.run.res[r_idx];
    assign w_sel_last = ((CNT_W'(r_idx) + 1'b1) == i_head.run.cnt);
    assign w_load     = i_head.valid && (!r_out_valid || o_out.ready);
    assign o_pop      = w_load && w_sel_last;

    assign o_out.valid        = r_out_valid;
    assign o_out.item_kind    = r_out.kind;
    assign o_out.content_byte = r_out.data;
    assign o_out.last_of_run  = r_out_last;

    // Step through the run; drop the head after its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx       <= w_sel_last ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold payload while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= w_sel;
            r_out_last <= w_sel_last;
        end
    end

endmodule

FILE: rtl/csv_field_row_splitter.sv
// CSV field/row splitter, top level.
// Depends on csvs_pkg, csvs_ifs, csvs_front, csvs_run_fifo and csvs_back.
//
// i_in carries one byte of CSV text per item with end_of_data on the final
// byte. o_out carries result items: content bytes, field ends and row ends,
// with last_of_run set on the final result caused by one input byte. Bytes
// that cause no result (BOM bytes, a held CR, an opening quote) leave no trace.
//
// Input is taken one byte per cycle while the queue is not full: the front
// resolves BOM, CR and quote handling for a byte combinationally and pushes
// the byte's results as one run into a QUEUE_DEPTH-entry queue. The back
// sends one result per cycle while the receiver is ready; sustained rate is
// one byte per cycle while each byte yields at most one result and the
// receiver is ready.
//
// Reset (synchronous, active low) empties the queue and output register and
// returns the parser to start of text. When the receiver stalls, the output
// holds; the queue fills, then i_in.ready drops until a run drains.
module csv_field_row_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csvs_in_if.sink     i_in,
    csvs_out_if.source  o_out
);

    csvs_pkg::t_push w_push;
    csvs_pkg::t_head w_head;
    logic            w_full;
    logic            w_pop;

    csvs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    csvs_run_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    csvs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
